// ===== hdl/pmi_pkg.sv =====
// Shared types and constants for the planar motion integrator.
package pmi_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic [16:0]        friction;
    logic [15:0]        time_step;
    logic [3:0]         contact_mask;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } out_word_t;

  // fields that ride along the pipeline unchanged
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        ts;
    logic [16:0]        fr;
  } carry_t;

  // velocity as sign and magnitude per axis
  typedef struct packed {
    logic        sx;
    logic        sy;
    logic [31:0] mx;
    logic [31:0] my;
  } vmag_t;

  localparam logic [1:0] REG_SPD_LIMIT = 2'd0;
  localparam logic [1:0] REG_PPM       = 2'd1;
  localparam logic [1:0] REG_STOP      = 2'd2;

  localparam logic [30:0] SPD_LIMIT_RST = 31'd32768000;
  localparam logic [10:0] PPM_RST       = 11'd32;
  localparam logic [16:0] STOP_RST      = 17'd6554;

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;

endpackage

// ===== hdl/planar_motion_integrator.sv =====
// Pipelined semi-implicit Euler step for one 2-D body per word.
// Throughput: one word per cycle while the output is not stalled; the 32-step
// square root and the two 31-step dividers are unrolled into register stages,
// so every stage advances together.
// A stall on the output freezes the whole pipeline and stalls the input.
// Reset clears all stage valid bits and loads the register defaults.
module planar_motion_integrator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pmi_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output pmi_pkg::out_word_t out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  localparam int NS = pmi_pkg::SQRT_STAGES;
  localparam int ND = pmi_pkg::DIV_STAGES;

  logic [30:0] spd_limit;
  logic [10:0] accel_scale;
  logic [16:0] stop_threshold;

  logic adv;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spd_limit      <= pmi_pkg::SPD_LIMIT_RST;
      accel_scale    <= pmi_pkg::PPM_RST;
      stop_threshold <= pmi_pkg::STOP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmi_pkg::REG_SPD_LIMIT: spd_limit <= cfg_data;
        pmi_pkg::REG_PPM:       accel_scale <= cfg_data[10:0];
        pmi_pkg::REG_STOP:      stop_threshold <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // ---------------- stage 1: contact blocking, scale ----------------
  logic               v1;
  pmi_pkg::carry_t    c1;
  logic signed [31:0] vx1, vy1;
  logic [31:0]        amx1, amy1;
  logic               anx1, any1, ex1, ey1;
  logic [26:0]        scale1;

  logic bnx, bpx, bny, bpy;
  assign bnx = in_word.contact_mask[0];
  assign bpx = in_word.contact_mask[1];
  assign bny = in_word.contact_mask[2];
  assign bpy = in_word.contact_mask[3];

  always_ff @(posedge clk) begin
    if (adv) begin
      c1.px  <= in_word.pos_x;
      c1.py  <= in_word.pos_y;
      c1.ts  <= in_word.time_step;
      c1.fr  <= in_word.friction;
      vx1    <= ((bnx && in_word.vel_x < 0) || (bpx && in_word.vel_x > 0)) ? '0 : in_word.vel_x;
      vy1    <= ((bny && in_word.vel_y < 0) || (bpy && in_word.vel_y > 0)) ? '0 : in_word.vel_y;
      ex1    <= !((bnx && in_word.accel_x < 0) || (bpx && in_word.accel_x > 0));
      ey1    <= !((bny && in_word.accel_y < 0) || (bpy && in_word.accel_y > 0));
      amx1   <= mag32(in_word.accel_x);
      amy1   <= mag32(in_word.accel_y);
      anx1   <= in_word.accel_x[31];
      any1   <= in_word.accel_y[31];
      scale1 <= 27'(in_word.time_step) * 27'(accel_scale);
    end
  end

  // ---------------- stage 2: acceleration product ----------------
  logic               v2;
  pmi_pkg::carry_t    c2;
  logic signed [31:0] vx2, vy2;
  logic               anx2, any2, ex2, ey2;
  logic [58:0]        prx2, pry2;

  always_ff @(posedge clk) begin
    if (adv) begin
      c2   <= c1;
      vx2  <= vx1;
      vy2  <= vy1;
      anx2 <= anx1;
      any2 <= any1;
      ex2  <= ex1;
      ey2  <= ey1;
      prx2 <= 59'(amx1) * 59'(scale1);
      pry2 <= 59'(amy1) * 59'(scale1);
    end
  end

  // ---------------- stage 3: velocity update with saturation ----------------
  function automatic logic signed [31:0] add_acc(input logic signed [31:0] v,
                                                 input logic [58:0] p,
                                                 input logic neg, input logic en);
    logic signed [44:0] d;
    logic signed [44:0] s;
    d = $signed({2'b00, p[58:16]});
    if (neg) d = -d;
    if (!en) d = '0;
    s = 45'(v) + d;
    if (s > 45'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (s < -45'sh80000000) return 32'sh80000000;
    return s[31:0];
  endfunction

  logic               v3;
  pmi_pkg::carry_t    c3;
  logic signed [31:0] vx3, vy3;

  always_ff @(posedge clk) begin
    if (adv) begin
      c3  <= c2;
      vx3 <= add_acc(vx2, prx2, anx2, ex2);
      vy3 <= add_acc(vy2, pry2, any2, ey2);
    end
  end

  // ---------------- stage 4: squares ----------------
  logic            v4;
  pmi_pkg::carry_t c4;
  pmi_pkg::vmag_t  m4;
  logic [63:0]     sqx4, sqy4;
  logic [31:0]     mx3, my3;
  assign mx3 = mag32(vx3);
  assign my3 = mag32(vy3);

  always_ff @(posedge clk) begin
    if (adv) begin
      c4    <= c3;
      m4.sx <= vx3[31];
      m4.sy <= vy3[31];
      m4.mx <= mx3;
      m4.my <= my3;
      sqx4  <= 64'(mx3) * 64'(mx3);
      sqy4  <= 64'(my3) * 64'(my3);
    end
  end

  // ---------------- stage 5 and square root chain ----------------
  logic            sq_v [0:NS];
  pmi_pkg::carry_t sq_c [0:NS];
  pmi_pkg::vmag_t  sq_m [0:NS];
  logic [63:0]     sq_n [0:NS];
  logic [63:0]     sq_r [0:NS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_c[0] <= c4;
      sq_m[0] <= m4;
      sq_n[0] <= sqx4 + sqy4;
      sq_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] t;
    assign t = sq_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_c[k+1] <= sq_c[k];
        sq_m[k+1] <= sq_m[k];
        if (sq_n[k] >= t) begin
          sq_n[k+1] <= sq_n[k] - t;
          sq_r[k+1] <= (sq_r[k] >> 1) + BIT;
        end else begin
          sq_n[k+1] <= sq_n[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // ---------------- limit stage and divider chains ----------------
  logic            dv_v   [0:ND];
  pmi_pkg::carry_t dv_c   [0:ND];
  pmi_pkg::vmag_t  dv_m   [0:ND];
  logic            dv_lim [0:ND];
  logic [31:0]     dv_d   [0:ND];
  logic [31:0]     dv_r   [0:1][0:ND];
  logic [30:0]     dv_n   [0:1][0:ND];
  logic [30:0]     dv_q   [0:1][0:ND];

  logic [31:0] speed;
  logic [62:0] lpx, lpy;
  assign speed = sq_r[NS][31:0];
  assign lpx   = 63'(sq_m[NS].mx) * 63'(spd_limit);
  assign lpy   = 63'(sq_m[NS].my) * 63'(spd_limit);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c[0]    <= sq_c[NS];
      dv_m[0]    <= sq_m[NS];
      dv_lim[0]  <= speed > {1'b0, spd_limit};
      dv_d[0]    <= speed;
      dv_r[0][0] <= lpx[62:31];
      dv_n[0][0] <= lpx[30:0];
      dv_q[0][0] <= '0;
      dv_r[1][0] <= lpy[62:31];
      dv_n[1][0] <= lpy[30:0];
      dv_q[1][0] <= '0;
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[j+1]   <= dv_c[j];
        dv_m[j+1]   <= dv_m[j];
        dv_lim[j+1] <= dv_lim[j];
        dv_d[j+1]   <= dv_d[j];
      end
    end
    for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [32:0] r2;
      logic        ge;
      logic [30:0] qn;
      assign r2 = {dv_r[a][j], dv_n[a][j][30-j]};
      assign ge = r2 >= {1'b0, dv_d[j]};
      always_comb begin
        qn = dv_q[a][j];
        qn[30-j] = ge;
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_n[a][j+1] <= dv_n[a][j];
          dv_q[a][j+1] <= qn;
          dv_r[a][j+1] <= ge ? 32'(r2 - {1'b0, dv_d[j]}) : r2[31:0];
        end
      end
    end
  end

  // ---------------- friction product ----------------
  logic            vf;
  pmi_pkg::carry_t cf;
  logic            sxf, syf;
  logic [48:0]     pfx, pfy;
  logic [31:0]     lmx, lmy;
  assign lmx = dv_lim[ND] ? {1'b0, dv_q[0][ND]} : dv_m[ND].mx;
  assign lmy = dv_lim[ND] ? {1'b0, dv_q[1][ND]} : dv_m[ND].my;

  always_ff @(posedge clk) begin
    if (adv) begin
      cf  <= dv_c[ND];
      sxf <= dv_m[ND].sx;
      syf <= dv_m[ND].sy;
      pfx <= 49'(lmx) * 49'(dv_c[ND].fr);
      pfy <= 49'(lmy) * 49'(dv_c[ND].fr);
    end
  end

  // ---------------- saturation and stop snap ----------------
  function automatic logic [31:0] snap(input logic [48:0] p, input logic neg,
                                       input logic [16:0] st);
    logic [32:0] m;
    logic [32:0] cap;
    m   = p[48:16];
    cap = neg ? 33'h080000000 : 33'h07FFFFFFF;
    if (m > cap) m = cap;
    if (m < {16'd0, st}) m = '0;
    return m[31:0];
  endfunction

  logic            vg;
  pmi_pkg::carry_t cg;
  pmi_pkg::vmag_t  mg;

  always_ff @(posedge clk) begin
    if (adv) begin
      cg    <= cf;
      mg.sx <= sxf;
      mg.sy <= syf;
      mg.mx <= snap(pfx, sxf, stop_threshold);
      mg.my <= snap(pfy, syf, stop_threshold);
    end
  end

  // ---------------- displacement product ----------------
  logic               vh;
  pmi_pkg::carry_t    ch;
  pmi_pkg::vmag_t     mh;
  logic [47:0]        pdx, pdy;

  always_ff @(posedge clk) begin
    if (adv) begin
      ch  <= cg;
      mh  <= mg;
      pdx <= 48'(mg.mx) * 48'(cg.ts);
      pdy <= 48'(mg.my) * 48'(cg.ts);
    end
  end

  // ---------------- position update, output register ----------------
  function automatic logic signed [31:0] add_pos(input logic signed [31:0] p,
                                                 input logic [47:0] d, input logic neg);
    logic signed [33:0] dd;
    logic signed [33:0] s;
    dd = $signed({2'b00, d[47:16]});
    if (neg) dd = -dd;
    s = 34'(p) + dd;
    if (s > 34'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (s < -34'sh80000000) return 32'sh80000000;
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.new_pos_x <= add_pos(ch.px, pdx, mh.sx);
      out_word.new_pos_y <= add_pos(ch.py, pdy, mh.sy);
      out_word.new_vel_x <= mh.sx ? 32'(-mh.mx) : mh.mx;
      out_word.new_vel_y <= mh.sy ? 32'(-mh.my) : mh.my;
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      for (int i = 0; i <= NS; i++) sq_v[i] <= 1'b0;
      for (int i = 0; i <= ND; i++) dv_v[i] <= 1'b0;
      vf        <= 1'b0;
      vg        <= 1'b0;
      vh        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1      <= in_valid;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      sq_v[0] <= v4;
      for (int i = 0; i < NS; i++) sq_v[i+1] <= sq_v[i];
      dv_v[0] <= sq_v[NS];
      for (int i = 0; i < ND; i++) dv_v[i+1] <= dv_v[i];
      vf        <= dv_v[ND];
      vg        <= vf;
      vh        <= vg;
      out_valid <= vh;
    end
  end

endmodule
